/* design/srpg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stepper ramp pulse generator.
// No dependencies; used by srpg_div and stepper_ramp_pulse_generator_top.
package srpg_pkg;

   // Field widths fixed by the interface
   localparam int BASE_W     = 16;                // base delay and half-period width
   localparam int MSTEP_W    = 9;                 // microsteps register width
   localparam int CSR_DATA_W = 16;                // widest register
   localparam int DIV_CNT_W  = $clog2(BASE_W);    // divider step counter

   // Register reset values
   localparam logic [BASE_W-1:0]  BASE_DELAY_RST = BASE_W'(200);
   localparam logic [MSTEP_W-1:0] MICROSTEPS_RST = MSTEP_W'(8);

   // Register indexes
   typedef enum logic {
      CSR_BASE_DELAY = 1'b0,
      CSR_MICROSTEPS = 1'b1
   } csr_index_type;

   // Item operation codes
   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   // Divider result toward the sequencer
   typedef struct packed {
      logic              done;
      logic [BASE_W-1:0] quotient;
   } div_result_type;

endpackage

/* design/srpg_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider: fixed-width dividend over a wide divisor, one bit per cycle.
// Depends on srpg_pkg.
module srpg_div #(
   parameter int DIVISOR_WIDTH = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [srpg_pkg::BASE_W-1:0]      dividend,
   input  logic [DIVISOR_WIDTH-1:0]         divisor,
   output srpg_pkg::div_result_type         result
);

   localparam int CMP_W = (DIVISOR_WIDTH > srpg_pkg::BASE_W + 1) ?
                          DIVISOR_WIDTH : srpg_pkg::BASE_W + 1;

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [srpg_pkg::DIV_CNT_W-1:0]     count_ff, count_in;
   logic [srpg_pkg::BASE_W-1:0]        rem_ff, rem_in;
   logic [srpg_pkg::BASE_W-1:0]        quot_ff, quot_in;

   logic [srpg_pkg::BASE_W:0]          trial;
   logic [CMP_W-1:0]                   trial_x;
   logic [CMP_W-1:0]                   divisor_x;
   logic [CMP_W-1:0]                   diff;
   logic                               fits;

   assign trial     = {rem_ff, quot_ff[srpg_pkg::BASE_W-1]};
   assign trial_x   = CMP_W'(trial);
   assign divisor_x = CMP_W'(divisor);
   assign fits      = (trial_x >= divisor_x);
   assign diff      = trial_x - divisor_x;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quot_in  = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[srpg_pkg::BASE_W-1:0] : trial[srpg_pkg::BASE_W-1:0];
         quot_in  = {quot_ff[srpg_pkg::BASE_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == srpg_pkg::DIV_CNT_W'(srpg_pkg::BASE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quot_ff;

endmodule

/* design/stepper_ramp_pulse_generator_top.sv */
`timescale 1ns / 1ps
// Two-motor trapezoidal step pulse generator: sequencer, move state and result register.
// Depends on srpg_pkg and srpg_div.
//
// Each input item is either a one-microsecond tick or a start command, and each gives
// exactly one result item with both step pin levels, both held direction levels, busy,
// start-taken and move-done flags. A start while a move runs is refused. A move of N
// steps drives high/low half periods of d ticks; d ramps up over the first third of
// the move (base / (microsteps * (i+1))), holds base / microsteps in the middle third
// and ramps down over the last third (base / (microsteps * (N-i))), with a zero delay
// forced to one tick and microsteps of zero taken as one. The ramp phase is found
// without dividing, by comparing 3*(i+1) against N and 2*N. The block takes one item
// at a time. An item that needs no new delay (a tick while idle or counting down, a
// refused or zero-step start, the tick that ends the move) is accepted, then loads the
// result register. A start of a move, or a tick that ends a high or low period with
// more of the move to come, goes through accept, phase select, multiply of microsteps
// by the ramp factor, then the shared radix-2 divider (one quotient bit per step, then
// a report) and the result load.
// A finished result waits in the result register while the next item is taken;
// the result is only loaded once the register is free. Registers may be written
// only while no item is in flight; a change applies at the next delay load.
module stepper_ramp_pulse_generator_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic                               req_motor_select,
   input  logic                               req_direction,
   input  logic [15:0]                        req_step_count,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_step_pin_one,
   output logic                               rsp_step_pin_two,
   output logic                               rsp_dir_pin_one,
   output logic                               rsp_dir_pin_two,
   output logic                               rsp_busy_res,
   output logic                               rsp_accepted,
   output logic                               rsp_move_done,
   // register writes
   input  logic                               csr_write,
   input  logic                               csr_index,
   input  logic [srpg_pkg::CSR_DATA_W-1:0]    csr_data
);

   // divisor = microsteps * factor, factor up to 2^COUNT_WIDTH
   localparam int FACTOR_W  = COUNT_WIDTH + 1;
   localparam int DIVISOR_W = srpg_pkg::MSTEP_W + FACTOR_W;
   localparam int PHASE_W   = COUNT_WIDTH + 3;

   typedef enum logic [2:0] {
      IDLE,     // waiting for an item
      PHASE,    // pick ramp factor
      MUL,      // microsteps * factor, kick divider
      DIV,      // wait for quotient
      EMIT      // load result register
   } state_type;

   typedef struct packed {
      logic step_pin_one;
      logic step_pin_two;
      logic dir_pin_one;
      logic dir_pin_two;
      logic busy_res;
      logic accepted;
      logic move_done;
   } rsp_fields_type;

   state_type                          state_ff, state_in;
   logic [srpg_pkg::BASE_W-1:0]        base_delay_ff, base_delay_in;
   logic [srpg_pkg::MSTEP_W-1:0]       microsteps_ff, microsteps_in;
   logic [COUNT_WIDTH-1:0]             step_index_ff, step_index_in;
   logic [COUNT_WIDTH-1:0]             total_steps_ff, total_steps_in;
   logic [srpg_pkg::BASE_W-1:0]        ticks_left_ff, ticks_left_in;
   logic                               pulse_high_ff, pulse_high_in;
   logic                               running_ff, running_in;
   logic                               active_motor_ff, active_motor_in;
   logic [1:0]                         dir_levels_ff, dir_levels_in;
   logic [COUNT_WIDTH-1:0]             div_index_ff, div_index_in;
   logic [FACTOR_W-1:0]                factor_ff, factor_in;
   logic [DIVISOR_W-1:0]               divisor_ff, divisor_in;
   rsp_fields_type                     pend_ff, pend_in;
   rsp_fields_type                     rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                               accept;
   logic                               div_start;
   srpg_pkg::div_result_type           div_res;

   // tick / start decode
   logic [COUNT_WIDTH-1:0]             cnt;
   logic [srpg_pkg::BASE_W-1:0]        ticks_dec;
   logic [COUNT_WIDTH-1:0]             index_next;
   logic                               need_div;
   logic                               hi;
   logic                               took_start;
   logic                               finished;

   // phase select
   logic [FACTOR_W-1:0]                idx_plus1;
   logic [PHASE_W-1:0]                 three_i1;
   logic [PHASE_W-1:0]                 n_x1;
   logic [PHASE_W-1:0]                 n_x2;
   logic [COUNT_WIDTH-1:0]             steps_left;
   logic [srpg_pkg::MSTEP_W-1:0]       m_eff;

   assign accept     = req_valid && (state_ff == IDLE);
   assign req_stall  = (state_ff != IDLE);
   assign div_start  = (state_ff == MUL);

   assign cnt        = COUNT_WIDTH'(req_step_count);
   assign ticks_dec  = (ticks_left_ff != '0) ? ticks_left_ff - 1'b1 : ticks_left_ff;
   assign index_next = step_index_ff + 1'b1;

   assign idx_plus1  = FACTOR_W'(div_index_ff) + 1'b1;
   assign three_i1   = PHASE_W'(idx_plus1) + PHASE_W'({idx_plus1, 1'b0});
   assign n_x1       = PHASE_W'(total_steps_ff);
   assign n_x2       = PHASE_W'({total_steps_ff, 1'b0});
   assign steps_left = total_steps_ff - div_index_ff;
   assign m_eff      = (microsteps_ff == '0) ? srpg_pkg::MSTEP_W'(1) : microsteps_ff;

   srpg_div #(
      .DIVISOR_WIDTH (DIVISOR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (base_delay_ff),
      .divisor  (divisor_ff),
      .result   (div_res)
   );

   always_comb begin
      state_in        = state_ff;
      base_delay_in   = base_delay_ff;
      microsteps_in   = microsteps_ff;
      step_index_in   = step_index_ff;
      total_steps_in  = total_steps_ff;
      ticks_left_in   = ticks_left_ff;
      pulse_high_in   = pulse_high_ff;
      running_in      = running_ff;
      active_motor_in = active_motor_ff;
      dir_levels_in   = dir_levels_ff;
      div_index_in    = div_index_ff;
      factor_in       = factor_ff;
      divisor_in      = divisor_ff;
      pend_in         = pend_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      need_div        = 1'b0;
      took_start      = 1'b0;
      finished        = 1'b0;
      hi              = 1'b0;

      if (csr_write) begin
         unique case (srpg_pkg::csr_index_type'(csr_index))
            srpg_pkg::CSR_BASE_DELAY: base_delay_in = csr_data;
            srpg_pkg::CSR_MICROSTEPS: microsteps_in = csr_data[srpg_pkg::MSTEP_W-1:0];
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               if (srpg_pkg::op_type'(req_operation) == srpg_pkg::OP_START) begin
                  if (!running_ff) begin
                     took_start = 1'b1;
                     dir_levels_in[req_motor_select] = req_direction;
                     active_motor_in = req_motor_select;
                     if (cnt != '0) begin
                        total_steps_in = cnt;
                        step_index_in  = '0;
                        pulse_high_in  = 1'b1;
                        running_in     = 1'b1;
                        div_index_in   = '0;
                        need_div       = 1'b1;
                     end
                  end
               end else if (running_ff) begin
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     if (pulse_high_ff) begin
                        pulse_high_in = 1'b0;
                        div_index_in  = step_index_ff;
                        need_div      = 1'b1;
                     end else begin
                        step_index_in = index_next;
                        if (index_next == total_steps_ff) begin
                           running_in = 1'b0;
                           finished   = 1'b1;
                        end else begin
                           pulse_high_in = 1'b1;
                           div_index_in  = index_next;
                           need_div      = 1'b1;
                        end
                     end
                  end
               end
               hi                   = running_in && pulse_high_in;
               pend_in.step_pin_one = hi && !active_motor_in;
               pend_in.step_pin_two = hi && active_motor_in;
               pend_in.dir_pin_one  = dir_levels_in[0];
               pend_in.dir_pin_two  = dir_levels_in[1];
               pend_in.busy_res     = running_in;
               pend_in.accepted     = took_start;
               pend_in.move_done    = finished;
               state_in             = need_div ? PHASE : EMIT;
            end
         end
         PHASE: begin
            // ramp up, cruise or ramp down
            priority if (three_i1 <= n_x1) begin
               factor_in = idx_plus1;
            end else if (three_i1 <= n_x2) begin
               factor_in = FACTOR_W'(1);
            end else begin
               factor_in = (steps_left == '0) ? FACTOR_W'(1) : FACTOR_W'(steps_left);
            end
            state_in = MUL;
         end
         MUL: begin
            divisor_in = DIVISOR_W'(m_eff) * DIVISOR_W'(factor_ff);
            state_in   = DIV;
         end
         DIV: begin
            if (div_res.done) begin
               ticks_left_in = (div_res.quotient == '0) ?
                               srpg_pkg::BASE_W'(1) : div_res.quotient;
               state_in      = EMIT;
            end
         end
         EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         base_delay_ff   <= srpg_pkg::BASE_DELAY_RST;
         microsteps_ff   <= srpg_pkg::MICROSTEPS_RST;
         step_index_ff   <= '0;
         total_steps_ff  <= '0;
         ticks_left_ff   <= '0;
         pulse_high_ff   <= 1'b0;
         running_ff      <= 1'b0;
         active_motor_ff <= 1'b0;
         dir_levels_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         base_delay_ff   <= base_delay_in;
         microsteps_ff   <= microsteps_in;
         step_index_ff   <= step_index_in;
         total_steps_ff  <= total_steps_in;
         ticks_left_ff   <= ticks_left_in;
         pulse_high_ff   <= pulse_high_in;
         running_ff      <= running_in;
         active_motor_ff <= active_motor_in;
         dir_levels_ff   <= dir_levels_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      div_index_ff <= div_index_in;
      factor_ff    <= factor_in;
      divisor_ff   <= divisor_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_pin_one = rsp_ff.step_pin_one;
   assign rsp_step_pin_two = rsp_ff.step_pin_two;
   assign rsp_dir_pin_one  = rsp_ff.dir_pin_one;
   assign rsp_dir_pin_two  = rsp_ff.dir_pin_two;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_move_done    = rsp_ff.move_done;

`ifndef SYNTH
   // a running move always has a half period loaded between items
   a_ticks_loaded : assert property (@(posedge clock) disable iff (reset)
      (running_ff && state_ff == IDLE) |-> (ticks_left_ff != '0))
      else $error("running move idle with no ticks left");

   // step index stays below the move length while running
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      (running_ff && state_ff == IDLE) |-> (step_index_ff < total_steps_ff))
      else $error("step index out of range");

   // divider reports only while the sequencer waits for it
   a_div_done_in_div : assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == DIV))
      else $error("divider done outside wait state");

   // a pending result is never overwritten before it is taken
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result lost");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for stepper_ramp_pulse_generator_top: pin-level scoreboard plus drivers.
// Depends on srpg_pkg and the RTL under design/.

module tb_top;

   localparam int CLK_PERIOD     = 10;
   localparam int CNT_W          = 16;    // COUNT_WIDTH of the instance
   localparam int SETTLE_CYCLES  = 40;    // margin after the last result before register writes
   localparam int HOLD_CYCLES    = 150;   // long result hold-off to back the block up
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 80;
   localparam int PRESSURE_PHASE = 2;
   localparam int MAX_PRINTS     = 30;

   // One result item: pin levels and status flags
   typedef struct packed {
      logic step_one;
      logic step_two;
      logic dir_one;
      logic dir_two;
      logic busy;
      logic taken;
      logic done;
   } pin_levels_type;

   // Tracks the move state, predicts pin levels per item and checks results in order.
   class pin_level_scoreboard;
      logic [15:0]      base_delay;
      logic [8:0]       microsteps;
      logic [CNT_W-1:0] step_index;
      logic [CNT_W-1:0] total_steps;
      logic [15:0]      ticks_left;
      logic             pulse_high;
      logic             running;
      logic             active_motor;
      logic [1:0]       dir_levels;
      pin_levels_type   pending_pins[$];
      int               mismatches;
      int               commands_seen;
      int               results_checked;

      function new();
         base_delay      = srpg_pkg::BASE_DELAY_RST;
         microsteps      = srpg_pkg::MICROSTEPS_RST;
         step_index      = '0;
         total_steps     = '0;
         ticks_left      = '0;
         pulse_high      = 1'b0;
         running         = 1'b0;
         active_motor    = 1'b0;
         dir_levels      = 2'b00;
         mismatches      = 0;
         commands_seen   = 0;
         results_checked = 0;
      endfunction

      function void write_reg(srpg_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            srpg_pkg::CSR_BASE_DELAY: base_delay = value;
            srpg_pkg::CSR_MICROSTEPS: microsteps = value[8:0];
            default: ;
         endcase
      endfunction

      // Middle-phase half period, used to keep random moves short
      function int middle_ticks();
         int m;
         m = (microsteps == 0) ? 1 : int'(microsteps);
         return int'(base_delay) / m;
      endfunction

      // Half period in ticks for step idx of the current move
      function logic [15:0] half_period_ticks(logic [CNT_W-1:0] idx);
         longint unsigned n, i, m, div, d;
         n = 64'(total_steps);
         i = 64'(idx);
         m = (microsteps == 0) ? 64'd1 : 64'(microsteps);
         if (i < n / 3)
            div = m * (i + 1);
         else if (i < (2 * n) / 3)
            div = m;
         else
            div = m * ((n > i) ? n - i : 64'd1);
         d = 64'(base_delay) / div;
         if (d == 0) d = 64'd1;
         return d[15:0];
      endfunction

      function void note_command(srpg_pkg::op_type op, logic sel, logic dir,
                                 logic [15:0] cnt);
         pin_levels_type due;
         logic           high_now;
         due = '0;
         if (op == srpg_pkg::OP_START) begin
            if (!running) begin
               due.taken         = 1'b1;
               dir_levels[sel]   = dir;
               active_motor      = sel;
               if (cnt != 0) begin
                  total_steps = cnt;
                  step_index  = '0;
                  pulse_high  = 1'b1;
                  running     = 1'b1;
                  ticks_left  = half_period_ticks('0);
               end
            end
         end else if (running) begin
            if (ticks_left > 0) ticks_left--;
            if (ticks_left == 0) begin
               if (pulse_high) begin
                  pulse_high = 1'b0;
                  ticks_left = half_period_ticks(step_index);
               end else begin
                  step_index++;
                  if (step_index == total_steps) begin
                     running  = 1'b0;
                     due.done = 1'b1;
                  end else begin
                     pulse_high = 1'b1;
                     ticks_left = half_period_ticks(step_index);
                  end
               end
            end
         end
         high_now     = running && pulse_high;
         due.step_one = high_now && !active_motor;
         due.step_two = high_now && active_motor;
         due.dir_one  = dir_levels[0];
         due.dir_two  = dir_levels[1];
         due.busy     = running;
         pending_pins.push_back(due);
         commands_seen++;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("%0t ERROR result %0d: %s", $time, results_checked, what);
      endtask

      task compare_pin(string name, logic got, logic want);
         if (got !== want)
            report_mismatch($sformatf("%s is %b, want %b", name, got, want));
      endtask

      task check_pins(pin_levels_type got);
         pin_levels_type due;
         if (pending_pins.size() == 0) begin
            report_mismatch("result item with no command outstanding");
            return;
         end
         due = pending_pins.pop_front();
         results_checked++;
         compare_pin("step_pin_one", got.step_one, due.step_one);
         compare_pin("step_pin_two", got.step_two, due.step_two);
         compare_pin("dir_pin_one", got.dir_one, due.dir_one);
         compare_pin("dir_pin_two", got.dir_two, due.dir_two);
         compare_pin("busy_res", got.busy, due.busy);
         compare_pin("accepted", got.taken, due.taken);
         compare_pin("move_done", got.done, due.done);
      endtask
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT hookup. Every input starts at a known value.
   // ------------------------------------------------------------------
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_operation    = 1'b0;
   logic        req_motor_select = 1'b0;
   logic        req_direction    = 1'b0;
   logic [15:0] req_step_count   = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_step_pin_one;
   logic        rsp_step_pin_two;
   logic        rsp_dir_pin_one;
   logic        rsp_dir_pin_two;
   logic        rsp_busy_res;
   logic        rsp_accepted;
   logic        rsp_move_done;
   logic        csr_write        = 1'b0;
   logic        csr_index        = 1'b0;
   logic [srpg_pkg::CSR_DATA_W-1:0] csr_data = '0;

   pin_level_scoreboard sb;
   pin_levels_type seen_pins;

   int sender_gap_pct     = 0;   // chance per cycle that the sender idles before an item
   int receiver_stall_pct = 0;   // chance per cycle that the receiver stalls
   int hold_asks          = 0;   // bumped by the stimulus to request a long hold-off
   int hold_served        = 0;
   int hold_left          = 0;
   int quiet_cycles       = 0;
   int settings_used      = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   stepper_ramp_pulse_generator_top #(
      .COUNT_WIDTH (CNT_W)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_motor_select (req_motor_select),
      .req_direction    (req_direction),
      .req_step_count   (req_step_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_step_pin_one (rsp_step_pin_one),
      .rsp_step_pin_two (rsp_step_pin_two),
      .rsp_dir_pin_one  (rsp_dir_pin_one),
      .rsp_dir_pin_two  (rsp_dir_pin_two),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_accepted     (rsp_accepted),
      .rsp_move_done    (rsp_move_done),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ------------------------------------------------------------------
   // Result side: check each accepted item, then pick next cycle's stall.
   // A pending hold-off request turns into HOLD_CYCLES of solid stall,
   // counted here so the sender keeps pushing until the block backs up.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_pins.step_one = rsp_step_pin_one;
            seen_pins.step_two = rsp_step_pin_two;
            seen_pins.dir_one  = rsp_dir_pin_one;
            seen_pins.dir_two  = rsp_dir_pin_two;
            seen_pins.busy     = rsp_busy_res;
            seen_pins.taken    = rsp_accepted;
            seen_pins.done     = rsp_move_done;
            sb.check_pins(seen_pins);
         end
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // Watchdog: any handshake resets the count; a long silence means a hang
   // or an expected result that never shows up.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sb.pending_pins.size());
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Drivers. Everything changes right after a rising edge. send_command
   // leaves valid high after acceptance so back-to-back items never
   // lower and raise valid in the same step; callers drop it via
   // let_block_settle.
   // ------------------------------------------------------------------
   task automatic send_command(srpg_pkg::op_type op, logic sel, logic dir,
                               logic [15:0] cnt);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_motor_select <= sel;
      req_direction    <= dir;
      req_step_count   <= cnt;
      do @(posedge clock); while (req_stall);
      sb.note_command(op, sel, dir, cnt);
   endtask

   // Tick with junk in the fields the block should ignore
   task automatic send_tick();
      send_command(srpg_pkg::OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   16'($urandom_range(16'hFFFF)));
   endtask

   // Drop valid, wait for every outstanding result, then give the block
   // time to go fully quiet before touching registers.
   task automatic let_block_settle();
      req_valid <= 1'b0;
      while (sb.pending_pins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] base, logic [15:0] msteps);
      csr_write <= 1'b1;
      csr_index <= srpg_pkg::CSR_BASE_DELAY;
      csr_data  <= base;
      @(posedge clock);
      sb.write_reg(srpg_pkg::CSR_BASE_DELAY, base);
      csr_index <= srpg_pkg::CSR_MICROSTEPS;
      csr_data  <= msteps;
      @(posedge clock);
      sb.write_reg(srpg_pkg::CSR_MICROSTEPS, msteps);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both
   task automatic set_idling(int mode);
      case (mode)
         1:       begin sender_gap_pct = 47; receiver_stall_pct = 0;  end
         2:       begin sender_gap_pct = 0;  receiver_stall_pct = 47; end
         3:       begin sender_gap_pct = 29; receiver_stall_pct = 29; end
         default: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // Mostly complete moves: a start, then ticks until done, with the odd
   // refused start mid-move and a few idle ticks and zero-step starts.
   // Only ticks during a move and starts offered while idle count.
   task automatic run_random_moves(int budget);
      int          sent;
      int          pick;
      int          cnt_top;
      logic [15:0] cnt;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (sb.running) begin
            if (pick < 8) begin
               send_command(srpg_pkg::OP_START, 1'($urandom_range(1)),
                            1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
            end else begin
               send_tick();
               sent++;
            end
         end else if (pick < 12) begin
            send_tick();
         end else begin
            cnt_top = (sb.middle_ticks() <= 2) ? 40 : 6;
            cnt     = (pick < 20) ? 16'd0 : 16'($urandom_range(cnt_top, 1));
            send_command(srpg_pkg::OP_START, 1'($urandom_range(1)),
                         1'($urandom_range(1)), cnt);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int phase_base;
      int phase_msteps;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, zero-step starts on both motors (direction
      // still latched), a short ramp with a refused start in the middle,
      // then zero base delay and zero microsteps.
      set_idling(0);
      send_command(srpg_pkg::OP_TICK, 1'b1, 1'b1, 16'hFFFF);
      send_command(srpg_pkg::OP_START, 1'b0, 1'b1, 16'd0);
      send_command(srpg_pkg::OP_START, 1'b1, 1'b1, 16'd0);
      send_command(srpg_pkg::OP_START, 1'b1, 1'b0, 16'd0);
      let_block_settle();
      set_config(16'd2, 16'd1);
      send_command(srpg_pkg::OP_START, 1'b0, 1'b1, 16'd3);
      send_command(srpg_pkg::OP_START, 1'b1, 1'b1, 16'hFFFF);   // busy, must be refused
      while (sb.running) send_tick();
      let_block_settle();
      set_config(16'd0, 16'd0);                                 // delay forced to one tick
      send_command(srpg_pkg::OP_START, 1'b1, 1'b1, 16'd1);
      while (sb.running) send_tick();

      // Random phases, each with its own register setting and idling mix.
      // A phase may end mid-move, so the next setting also lands during
      // a move and must only apply from the next delay load.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         let_block_settle();
         case (ph)
            0:       begin phase_base = 1;   phase_msteps = 256; end
            1:       begin phase_base = 12;  phase_msteps = 3;   end
            2:       begin phase_base = 40;  phase_msteps = 16;  end
            3:       begin phase_base = 0;   phase_msteps = 0;   end
            4:       begin phase_base = 9;   phase_msteps = 1;   end
            5:       begin phase_base = 300; phase_msteps = 256; end
            6:       begin phase_base = 16;  phase_msteps = 4;   end
            default: begin
               phase_base   = $urandom_range(12, 1);
               phase_msteps = $urandom_range(8, 1);
            end
         endcase
         set_config(16'(phase_base), 16'(phase_msteps));
         set_idling(ph % 4);
         if (ph == PRESSURE_PHASE) hold_asks++;
         run_random_moves(PHASE_ITEMS);
      end

      // Finish whatever move is open, then the widest case: full base
      // delay and a full-range step count, run for a few ticks only.
      while (sb.running) send_tick();
      let_block_settle();
      set_config(16'hFFFF, 16'd1);
      set_idling(3);
      send_command(srpg_pkg::OP_START, 1'b1, 1'b0, 16'hFFFF);
      send_command(srpg_pkg::OP_START, 1'b0, 1'b1, 16'd0);      // refused while running
      repeat (20) send_tick();
      let_block_settle();

      $display("Checked %0d result items against %0d input items over %0d register settings,",
               sb.results_checked, sb.commands_seen, settings_used);
      $display("with mixed sender gaps and receiver stalls and one long result hold-off.");
      if (sb.mismatches == 0 && sb.pending_pins.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
design/srpg_pkg.sv
design/srpg_div.sv
design/stepper_ramp_pulse_generator_top.sv
dv/tb_top.sv
